@@ rtl/core/isort_pkg.sv @@
package isort_pkg;

  localparam int MAX_ITEMS_DEF = 16;
  localparam int VALUE_W       = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    value_t value;
    logic   last;
  } in_t;

  typedef struct packed {
    value_t value_res;
    logic   last_res;
    logic   overflow;
  } out_t;

  typedef struct packed {
    logic   valid;
    value_t val;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ rtl/core/isort_cell.sv @@
module isort_cell
  import isort_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  value_t     new_val,
  input  logic       left_gt,
  input  entry_t     left_entry,
  input  entry_t     right_entry,
  output entry_t     entry,
  output logic       gt
);

  entry_t entry_r;
  entry_t entry_nxt;

  assign gt    = !entry_r.valid || (entry_r.val > new_val);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.shift) begin
      entry_nxt = right_entry;
    end else if (ctrl.ins && gt) begin
      if (left_gt) begin
        entry_nxt = left_entry;
      end else begin
        entry_nxt.valid = 1'b1;
        entry_nxt.val   = new_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.val <= entry_nxt.val;
  end

endmodule

@@ rtl/core/insertion_sorter_unit.sv @@
// Streaming insertion sorter built from a row of MAX_ITEMS compare-and-shift cells.
// While loading, one value is transferred per cycle: every cell compares it at once
// and the entries above the insertion point move up by one place, so busy stays low.
// The transfer flagged last closes the set; from the next cycle busy is high and the
// row shifts down one place per cycle, presenting one result per cycle on out_data
// with out_valid high, smallest first. Results cannot be stalled: out_valid is a
// one-cycle strobe and the receiver must take each result in that cycle. Values
// beyond MAX_ITEMS are dropped and every result of that set carries overflow.
module insertion_sorter_unit
  import isort_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  entry_t     entries   [MAX_ITEMS];
  entry_t     left_e    [MAX_ITEMS];
  entry_t     right_e   [MAX_ITEMS];
  logic       gts       [MAX_ITEMS];
  logic       left_gts  [MAX_ITEMS];
  cell_ctrl_t ctrl;
  logic       accept;
  logic       full;
  logic       drain_r;
  logic       drain_nxt;
  logic       dropped_r;
  logic       dropped_nxt;
  logic       final_out;

  assign accept    = start && !drain_r;
  assign full      = entries[MAX_ITEMS-1].valid;
  assign ctrl.ins  = accept && !full;
  assign ctrl.shift = drain_r;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign left_e[gi]   = '0;
        assign left_gts[gi] = 1'b0;
      end else begin : g_mid
        assign left_e[gi]   = entries[gi-1];
        assign left_gts[gi] = gts[gi-1];
      end
      if (gi == MAX_ITEMS - 1) begin : g_end
        assign right_e[gi] = '0;
      end else begin : g_inner
        assign right_e[gi] = entries[gi+1];
      end

      isort_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_val    (in_data.value),
        .left_gt    (left_gts[gi]),
        .left_entry (left_e[gi]),
        .right_entry(right_e[gi]),
        .entry      (entries[gi]),
        .gt         (gts[gi])
      );
    end
  endgenerate

  assign final_out = !entries[1].valid;

  always_comb begin
    drain_nxt   = drain_r;
    dropped_nxt = dropped_r;
    if (drain_r) begin
      if (final_out) begin
        drain_nxt   = 1'b0;
        dropped_nxt = 1'b0;
      end
    end else if (accept) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end
      if (in_data.last) begin
        drain_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r   <= 1'b0;
      dropped_r <= 1'b0;
    end else begin
      drain_r   <= drain_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  assign busy               = drain_r;
  assign out_valid          = drain_r && entries[0].valid;
  assign out_data.value_res = entries[0].val;
  assign out_data.last_res  = final_out;
  assign out_data.overflow  = dropped_r;

endmodule

@@ verif/insertion_sorter_unit_tb.sv @@
module insertion_sorter_unit_tb;
  import isort_pkg::*;

  localparam int CAP = MAX_ITEMS_DEF;
  localparam int ITEM_TARGET = 230;
  localparam int TAIL_ITEMS = 40;

  localparam int VALS_RANDOM = 0;
  localparam int VALS_NARROW = 1;
  localparam int VALS_EXTREME = 2;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  value_t shadow_store [CAP];
  int     shadow_fill;
  bit     shadow_dropped;
  out_t   sorted_expect_q [$];
  out_t   want_res;
  int     sent_count;
  int     error_count;
  bit     paused_once;

  insertion_sorter_unit #(
    .MAX_ITEMS(CAP)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Inserts one accepted value into the shadow row (or notes it dropped if the row
  // is full) and, when the set closes, queues the whole row in ascending order.
  function automatic void predict_sorted_output(input in_t item);
    int   pos;
    out_t res;
    if (shadow_fill >= CAP) begin
      shadow_dropped = 1'b1;
    end else begin
      pos = shadow_fill;
      while (pos > 0 && $signed(shadow_store[pos-1]) > $signed(item.value)) begin
        shadow_store[pos] = shadow_store[pos-1];
        pos--;
      end
      shadow_store[pos] = item.value;
      shadow_fill++;
    end
    if (item.last) begin
      for (int k = 0; k < shadow_fill; k++) begin
        res.value_res = shadow_store[k];
        res.last_res  = (k == shadow_fill - 1);
        res.overflow  = shadow_dropped;
        sorted_expect_q.push_back(res);
      end
      shadow_fill    = 0;
      shadow_dropped = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (sorted_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d",
                                  $signed(out_data.value_res)));
      end else begin
        want_res = sorted_expect_q.pop_front();
        if (out_data.value_res !== want_res.value_res)
          report_mismatch($sformatf("value_res %0d, wanted %0d",
                                    $signed(out_data.value_res),
                                    $signed(want_res.value_res)));
        if (out_data.last_res !== want_res.last_res)
          report_mismatch($sformatf("last_res %b, wanted %b",
                                    out_data.last_res, want_res.last_res));
        if (out_data.overflow !== want_res.overflow)
          report_mismatch($sformatf("overflow %b, wanted %b",
                                    out_data.overflow, want_res.overflow));
      end
    end
  end

  // The item stays on the port after its transfer; the next call or an idle
  // stretch replaces it at the following falling edge.
  task automatic send_item(input value_t value, input bit last);
    in_t item;
    item.value = value;
    item.last  = last;
    @(negedge clk);
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_sorted_output(item);
    sent_count++;
  endtask

  task automatic idle_sender(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sorted_expect_q.size() != 0) @(negedge clk);
  endtask

  function automatic value_t pick_value(input int mode);
    case (mode)
      VALS_NARROW: return value_t'(int'($urandom_range(0, 8)) - 4);
      VALS_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return '0;
          default: return value_t'($urandom);
        endcase
      end
      default: return value_t'($urandom);
    endcase
  endfunction

  function automatic int pick_set_size();
    int r;
    r = int'($urandom_range(0, 9));
    if (r < 6) return int'($urandom_range(1, 8));
    if (r < 8) return int'($urandom_range(9, CAP));
    return int'($urandom_range(CAP + 1, CAP + 4));
  endfunction

  task automatic send_set(input int size, input int mode, input bit with_gaps);
    for (int i = 0; i < size; i++) begin
      if (with_gaps && $urandom_range(0, 3) == 0) idle_sender(int'($urandom_range(1, 19)));
      send_item(pick_value(mode), i == size - 1);
    end
  endtask

  task automatic test_extreme_values();
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh0000_0000, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sh5555_5555, 1'b0);
    send_item(32'shaaaa_aaaa, 1'b1);
  endtask

  task automatic test_single_item_set();
    send_item(value_t'($urandom), 1'b1);
  endtask

  task automatic test_equal_keys();
    send_item(32'sd3, 1'b0);
    send_item(-32'sd2, 1'b0);
    send_item(32'sd3, 1'b0);
    send_item(-32'sd2, 1'b0);
    send_item(32'sd3, 1'b1);
  endtask

  task automatic test_descending_input();
    send_item(32'sd400, 1'b0);
    send_item(32'sd300, 1'b0);
    send_item(-32'sd200, 1'b0);
    send_item(-32'sd900, 1'b1);
  endtask

  task automatic test_random_sets();
    while (sent_count < ITEM_TARGET - TAIL_ITEMS) begin
      send_set(pick_set_size(), int'($urandom_range(VALS_RANDOM, VALS_EXTREME)),
               $urandom_range(0, 2) != 0);
      if (!paused_once || $urandom_range(0, 9) == 0) begin
        wait_results_drained();
        paused_once = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        idle_sender(int'($urandom_range(1, 19)));
      end
    end
  endtask

  task automatic test_back_to_back_tail();
    while (sent_count < ITEM_TARGET)
      send_set(pick_set_size(), int'($urandom_range(VALS_RANDOM, VALS_EXTREME)), 1'b0);
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_data        = '0;
    shadow_fill    = 0;
    shadow_dropped = 1'b0;
    sent_count     = 0;
    error_count    = 0;
    paused_once    = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_extreme_values();
    test_single_item_set();
    test_equal_keys();
    test_descending_input();
    test_random_sets();
    test_back_to_back_tail();

    wait_results_drained();
    repeat (CAP + 4) @(negedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
